// ===== rtl/modbus_rtu_gripper_frame_engine_unit_assert.svh =====
// assertion macros for the gripper frame engine
// used by modbus_rtu_gripper_frame_engine_unit, no other dependencies
`ifndef MODBUS_RTU_GRIPPER_FRAME_ENGINE_UNIT_ASSERT_SVH
`define MODBUS_RTU_GRIPPER_FRAME_ENGINE_UNIT_ASSERT_SVH

// same-cycle implication
`define MRGFE_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// next-cycle implication
`define MRGFE_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

// ===== rtl/mrgfe_pkg.sv =====
// shared types, codes and frame constants for the gripper frame engine
// no dependencies
package mrgfe_pkg;

   typedef enum logic [1:0] {
      FUNC_COMMAND = 2'd0,
      FUNC_STATUS  = 2'd1,
      FUNC_RX_BYTE = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      KIND_TX       = 2'd0,
      KIND_STATUS   = 2'd1,
      KIND_BAD      = 2'd2,
      KIND_WRITE_OK = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      EXP_NONE  = 2'd0,
      EXP_WRITE = 2'd1,
      EXP_READ  = 2'd2
   } expect_type;

   typedef enum logic [1:0] {
      CRC_HOLD = 2'd0,
      CRC_INIT = 2'd1,
      CRC_FEED = 2'd2
   } crc_op_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_TX   = 2'd1,
      ST_RX   = 2'd2,
      ST_DONE = 2'd3
   } state_type;

   typedef struct packed {
      logic       restart;
      expect_type expect_code;
      logic       store;
   } rx_ctrl_type;

   typedef struct packed {
      expect_type expect_code;
      logic       feed_crc;
      logic       final_byte;
      logic       overrun;
   } rx_stat_type;

   localparam logic [15:0] CRC_SEED    = 16'hFFFF;
   localparam logic [15:0] CRC_POLY    = 16'hA001;
   localparam logic [7:0]  FN_WRITE    = 8'h10;
   localparam logic [7:0]  FN_READ     = 8'h03;
   localparam logic [3:0]  TX_LAST_WR  = 4'd14;
   localparam logic [3:0]  TX_LAST_RD  = 4'd7;
   localparam logic [3:0]  REPLY_LEN_WR = 4'd8;
   localparam logic [3:0]  REPLY_LEN_RD = 4'd11;
   localparam int          DATA_W      = 48;

   // header and payload bytes of both frames, crc bytes excluded
   function automatic logic [7:0] frame_byte(input logic is_write, input logic [3:0] idx,
                                             input logic [7:0] slave, input logic [7:0] ctrl,
                                             input logic [7:0] pos, input logic [7:0] speed,
                                             input logic [7:0] force_req);
      logic [7:0] b;
      b = 8'h00;
      case (idx)
         4'd0:  b = slave;
         4'd1:  b = is_write ? FN_WRITE : FN_READ;
         4'd2:  b = is_write ? 8'h03 : 8'h07;
         4'd3:  b = is_write ? 8'hE8 : 8'hD0;
         4'd5:  b = 8'h03;
         4'd6:  b = 8'h06;
         4'd7:  b = ctrl;
         4'd10: b = pos;
         4'd11: b = speed;
         4'd12: b = force_req;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

// ===== rtl/mrgfe_crc16.sv =====
// shared crc-16 unit: one register, one byte folded in per cycle while op is CRC_FEED
// depends on mrgfe_pkg
module mrgfe_crc16 (
   input  logic                 clock,
   input  logic                 reset,
   input  mrgfe_pkg::crc_op_type op,
   input  logic [7:0]           data,
   output logic [15:0]          crc
);

   logic [15:0] crc_ff;
   logic [15:0] crc_in;
   logic [15:0] fold;

   always_comb begin
      fold = crc_ff ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (fold[0]) begin
            fold = (fold >> 1) ^ mrgfe_pkg::CRC_POLY;
         end else begin
            fold = fold >> 1;
         end
      end
      case (op)
         mrgfe_pkg::CRC_INIT: crc_in = mrgfe_pkg::CRC_SEED;
         mrgfe_pkg::CRC_FEED: crc_in = fold;
         default:             crc_in = crc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= mrgfe_pkg::CRC_SEED;
      end else begin
         crc_ff <= crc_in;
      end
   end

   assign crc = crc_ff;

endmodule

// ===== rtl/mrgfe_rx.sv =====
// reply receiver: byte store, fill count and status parsing
// depends on mrgfe_pkg
module mrgfe_rx (
   input  logic                  clock,
   input  logic                  reset,
   input  mrgfe_pkg::rx_ctrl_type ctrl,
   input  logic [7:0]            rx_byte,
   input  logic [7:0]            slave_address,
   input  logic [15:0]           crc,
   output mrgfe_pkg::rx_stat_type stat,
   output mrgfe_pkg::kind_type   result_kind,
   output logic [mrgfe_pkg::DATA_W-1:0] result_data
);

   logic [7:0]            reply_bytes_ff [11];
   logic [3:0]            count_ff;
   logic [3:0]            count_in;
   mrgfe_pkg::expect_type expect_ff;
   mrgfe_pkg::expect_type expect_in;
   logic [3:0]            reply_len;
   logic [15:0]           got;
   logic                  crc_ok;
   logic [7:0]            s;

   always_comb begin
      count_in  = count_ff;
      expect_in = expect_ff;
      if (ctrl.restart) begin
         count_in  = 4'd0;
         expect_in = ctrl.expect_code;
      end else if (ctrl.store) begin
         count_in = count_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 4'd0;
         expect_ff <= mrgfe_pkg::EXP_NONE;
      end else begin
         count_ff  <= count_in;
         expect_ff <= expect_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.store) begin
         reply_bytes_ff[count_ff] <= rx_byte;
      end
   end

   assign reply_len = (expect_ff == mrgfe_pkg::EXP_WRITE) ? mrgfe_pkg::REPLY_LEN_WR
                                                           : mrgfe_pkg::REPLY_LEN_RD;

   always_comb begin
      stat.expect_code = expect_ff;
      stat.feed_crc    = count_ff < (reply_len - 4'd2);
      stat.final_byte  = count_ff == (reply_len - 4'd1);
      stat.overrun     = count_ff >= reply_len;
   end

   // crc travels low byte first in the last two reply bytes
   assign got = (expect_ff == mrgfe_pkg::EXP_WRITE) ? {reply_bytes_ff[7], reply_bytes_ff[6]}
                                                     : {reply_bytes_ff[10], reply_bytes_ff[9]};
   assign crc_ok = got == crc;
   assign s = reply_bytes_ff[3];

   always_comb begin
      result_data = '0;
      if (expect_ff == mrgfe_pkg::EXP_WRITE) begin
         result_kind = crc_ok ? mrgfe_pkg::KIND_WRITE_OK : mrgfe_pkg::KIND_BAD;
      end else if (!crc_ok || reply_bytes_ff[0] != slave_address) begin
         result_kind = mrgfe_pkg::KIND_BAD;
      end else begin
         result_kind        = mrgfe_pkg::KIND_STATUS;
         result_data[8]     = s[0];
         result_data[9]     = s[3];
         result_data[11:10] = s[5:4];
         result_data[13:12] = s[7:6];
         result_data[17:14] = reply_bytes_ff[5][3:0];
         result_data[21:18] = reply_bytes_ff[5][7:4];
         result_data[29:22] = reply_bytes_ff[6];
         result_data[37:30] = reply_bytes_ff[7];
         result_data[45:38] = reply_bytes_ff[8];
      end
   end

endmodule

// ===== rtl/modbus_rtu_gripper_frame_engine_unit.sv =====
// top level of the modbus rtu gripper frame engine: sequencer and result register
// depends on mrgfe_pkg, mrgfe_crc16, mrgfe_rx and the assertion macro header
//
// usage: items enter on the req_ channel, results leave on the rsp_ channel.
// req_tuser selects the item: command frame, status request or received byte.
// a command emits 15 transmit items, a status request 8, one per cycle while
// the receiver keeps rsp_tready high; the last one carries rsp_tlast.
// a frame's first byte reaches the output register once the sequencer has
// entered its transmit state, and the frame holds the block until its last
// byte is loaded; header and payload bytes pass through the one shared crc register.
// a received byte passes through the receive state; the byte that completes
// a reply goes on to the done state and yields one result item (good status,
// bad frame or write confirmed), which the done state loads into the output register.
// req_tready is high only while the sequencer is idle, so a new item waits
// until the current one is fully handed to the output register.
// when rsp_tready is low the output register holds its item and the
// sequencer pauses; nothing is dropped.
// reset (synchronous) clears the sequencer, the output valid flag and the receiver
// state and reloads the crc seed; the slave address returns to 9.
// csr_wen writes csr_wdata into the slave address; write only while idle.
module modbus_rtu_gripper_frame_engine_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // activate, go, auto_release, auto_release_dir, position, speed, force_req, rx_byte
   input  logic [39:0] req_tdata,
   // func
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // byte_out, activated, go_echo, gripper_state, object_state, fault_software,
   // fault_hardware, pos_echo, finger_position, motor_current
   output logic [47:0] rsp_tdata,
   // kind
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_wen,
   input  logic [7:0]  csr_wdata
);

   `include "modbus_rtu_gripper_frame_engine_unit_assert.svh"

   mrgfe_pkg::state_type   state_ff, state_in;
   mrgfe_pkg::rx_ctrl_type rx_ctrl;
   mrgfe_pkg::rx_stat_type rx_stat;
   mrgfe_pkg::kind_type    result_kind;
   mrgfe_pkg::crc_op_type  crc_op;
   mrgfe_pkg::func_type    func;

   logic [7:0]  slave_ff;
   logic [3:0]  idx_ff, idx_in;
   logic        is_write_ff, is_write_in;
   logic [7:0]  ctrl_ff, pos_ff, speed_ff, force_ff, rx_byte_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_kind_ff, rsp_kind_in;
   logic        rsp_last_ff, rsp_last_in;
   logic [47:0] rsp_data_ff, rsp_data_in;
   logic [47:0] result_data;
   logic [15:0] crc;
   logic [7:0]  crc_byte, tx_byte;
   logic [3:0]  last_idx;
   logic        accept, out_free, load;

   assign req_tready = state_ff == mrgfe_pkg::ST_IDLE;
   assign accept     = req_tvalid && req_tready;
   assign func       = mrgfe_pkg::func_type'(req_tuser);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign last_idx   = is_write_ff ? mrgfe_pkg::TX_LAST_WR : mrgfe_pkg::TX_LAST_RD;

   always_comb begin
      if (idx_ff == last_idx - 4'd1) begin
         tx_byte = crc[7:0];
      end else if (idx_ff == last_idx) begin
         tx_byte = crc[15:8];
      end else begin
         tx_byte = mrgfe_pkg::frame_byte(is_write_ff, idx_ff, slave_ff, ctrl_ff,
                                         pos_ff, speed_ff, force_ff);
      end
   end

   assign crc_byte = (state_ff == mrgfe_pkg::ST_TX) ? tx_byte : rx_byte_ff;

   always_comb begin
      state_in            = state_ff;
      idx_in              = idx_ff;
      is_write_in         = is_write_ff;
      crc_op              = mrgfe_pkg::CRC_HOLD;
      rx_ctrl.restart     = 1'b0;
      rx_ctrl.expect_code = mrgfe_pkg::EXP_NONE;
      rx_ctrl.store       = 1'b0;
      load                = 1'b0;
      rsp_kind_in         = mrgfe_pkg::KIND_TX;
      rsp_last_in         = 1'b0;
      rsp_data_in         = '0;
      unique case (state_ff)
         mrgfe_pkg::ST_IDLE: begin
            if (accept) begin
               case (func) inside
                  mrgfe_pkg::FUNC_COMMAND, mrgfe_pkg::FUNC_STATUS: begin
                     is_write_in         = func == mrgfe_pkg::FUNC_COMMAND;
                     idx_in              = 4'd0;
                     crc_op              = mrgfe_pkg::CRC_INIT;
                     rx_ctrl.restart     = 1'b1;
                     rx_ctrl.expect_code = (func == mrgfe_pkg::FUNC_COMMAND)
                                           ? mrgfe_pkg::EXP_WRITE : mrgfe_pkg::EXP_READ;
                     state_in            = mrgfe_pkg::ST_TX;
                  end
                  mrgfe_pkg::FUNC_RX_BYTE: begin
                     // bytes with no reply pending are dropped
                     if (rx_stat.expect_code == mrgfe_pkg::EXP_WRITE ||
                         rx_stat.expect_code == mrgfe_pkg::EXP_READ) begin
                        state_in = mrgfe_pkg::ST_RX;
                     end
                  end
                  default: ;
               endcase
            end
         end
         mrgfe_pkg::ST_TX: begin
            if (out_free) begin
               load           = 1'b1;
               rsp_data_in[7:0] = tx_byte;
               rsp_last_in    = idx_ff == last_idx;
               idx_in         = idx_ff + 4'd1;
               if (idx_ff < last_idx - 4'd1) begin
                  crc_op = mrgfe_pkg::CRC_FEED;
               end else if (idx_ff == last_idx) begin
                  crc_op   = mrgfe_pkg::CRC_INIT;
                  state_in = mrgfe_pkg::ST_IDLE;
               end
            end
         end
         mrgfe_pkg::ST_RX: begin
            if (rx_stat.overrun) begin
               rx_ctrl.restart = 1'b1;
               crc_op          = mrgfe_pkg::CRC_INIT;
               state_in        = mrgfe_pkg::ST_IDLE;
            end else begin
               rx_ctrl.store = 1'b1;
               if (rx_stat.feed_crc) begin
                  crc_op = mrgfe_pkg::CRC_FEED;
               end
               state_in = rx_stat.final_byte ? mrgfe_pkg::ST_DONE : mrgfe_pkg::ST_IDLE;
            end
         end
         mrgfe_pkg::ST_DONE: begin
            if (out_free) begin
               load            = 1'b1;
               rsp_kind_in     = result_kind;
               rsp_data_in     = result_data;
               rx_ctrl.restart = 1'b1;
               crc_op          = mrgfe_pkg::CRC_INIT;
               state_in        = mrgfe_pkg::ST_IDLE;
            end
         end
         default: state_in = mrgfe_pkg::ST_IDLE;
      endcase
      rsp_valid_in = load || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mrgfe_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         slave_ff     <= 8'd9;
         idx_ff       <= 4'd0;
         is_write_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         is_write_ff  <= is_write_in;
         if (csr_wen) begin
            slave_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ctrl_ff    <= {2'b00, req_tdata[3], req_tdata[2], req_tdata[1], 2'b00, req_tdata[0]};
         pos_ff     <= req_tdata[11:4];
         speed_ff   <= req_tdata[19:12];
         force_ff   <= req_tdata[27:20];
         rx_byte_ff <= req_tdata[35:28];
      end
      if (load) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_last_ff <= rsp_last_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

   mrgfe_crc16 u_crc (
      .clock (clock),
      .reset (reset),
      .op    (crc_op),
      .data  (crc_byte),
      .crc   (crc)
   );

   mrgfe_rx u_rx (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (rx_ctrl),
      .rx_byte       (rx_byte_ff),
      .slave_address (slave_ff),
      .crc           (crc),
      .stat          (rx_stat),
      .result_kind   (result_kind),
      .result_data   (result_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = rsp_data_ff;

   // a frame byte is handed to the output whenever it has room
   `MRGFE_ASSERT_NXT(a_tx_emits, clock, reset,
      state_ff == mrgfe_pkg::ST_TX && out_free,
      rsp_tvalid && rsp_tuser == mrgfe_pkg::KIND_TX)
   // only transmit items close a frame
   `MRGFE_ASSERT_IMP(a_last_is_tx, clock, reset,
      rsp_tvalid && rsp_tlast, rsp_tuser == mrgfe_pkg::KIND_TX)
   // a command restarts the crc and arms the write reply
   `MRGFE_ASSERT_NXT(a_cmd_arms, clock, reset,
      accept && func == mrgfe_pkg::FUNC_COMMAND,
      crc == mrgfe_pkg::CRC_SEED && rx_stat.expect_code == mrgfe_pkg::EXP_WRITE)
   // after a reply result the receiver is back to idle
   `MRGFE_ASSERT_NXT(a_done_idle, clock, reset,
      state_ff == mrgfe_pkg::ST_DONE && out_free,
      state_ff == mrgfe_pkg::ST_IDLE && rx_stat.expect_code == mrgfe_pkg::EXP_NONE)

endmodule
